// File: hdl/first_point_within_radius_search_assert.svh
// Assertion macros shared by the checker of the radius search block.
`ifndef FIRST_POINT_WITHIN_RADIUS_SEARCH_ASSERT_SVH
`define FIRST_POINT_WITHIN_RADIUS_SEARCH_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define FPRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FPRS_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/fprs_pkg.sv
// Shared types, constants and helpers of the radius search block.
package fprs_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int MAX_POINTS_DEF = 65536;
    localparam int RADIUS_BITS    = 52;
    localparam int INDEX_BITS     = 16;
    localparam int CFG_INDEX_BITS = 2;

    // Queue depths; both must be powers of two.
    localparam int MID_DEPTH = 8;
    localparam int OUT_DEPTH = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_QUERY_X = 2'd0,
        REG_QUERY_Y = 2'd1,
        REG_QUERY_Z = 2'd2
    } cfg_reg_t;

    // Classified point handed from the distance pipeline to the sequencer.
    typedef struct packed {
        logic hit;
        logic last;
    } mid_item_t;

    // Occupancy of the distance pipeline stages.
    typedef struct packed {
        logic a_valid;
        logic b_valid;
        logic c_valid;
    } front_stat_t;

    typedef struct packed {
        logic                  found;
        logic [INDEX_BITS-1:0] index;
    } result_t;

    // Largest index the point counter reaches.
    function automatic logic [INDEX_BITS-1:0] index_cap(input int max_points);
        int idx_max;
        idx_max = (1 << INDEX_BITS) - 1;
        if (max_points - 1 > idx_max)
            return INDEX_BITS'(idx_max);
        return INDEX_BITS'(max_points - 1);
    endfunction

endpackage

// File: hdl/fprs_queue.sv
// Small register FIFO with occupancy count; DEPTH must be a power of two.
module fprs_queue
    import fprs_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign count = count_reg;
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(do_wr) - CW'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/fprs_front.sv
// Distance pipeline: classify each point as inside or outside its radius.
module fprs_front
    import fprs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [COORD_BITS-1:0]  point_x,
    input  logic [COORD_BITS-1:0]  point_y,
    input  logic [COORD_BITS-1:0]  point_z,
    input  logic [RADIUS_BITS-1:0] radius_sq,
    input  logic                   last_point,
    input  logic [COORD_BITS-1:0]  query_x,
    input  logic [COORD_BITS-1:0]  query_y,
    input  logic [COORD_BITS-1:0]  query_z,
    output logic                   out_valid,
    output mid_item_t              out_item,
    output front_stat_t            stat
);

    localparam int CB   = COORD_BITS;
    localparam int SQW  = 2 * CB;
    localparam int SUMW = SQW + 2;
    localparam int CMPW = (SUMW > RADIUS_BITS) ? SUMW : RADIUS_BITS;

    // Stage A: absolute coordinate differences.
    logic                   a_valid_reg, a_valid_next;
    logic [CB-1:0]          mag_x_reg, mag_y_reg, mag_z_reg;
    logic [CB-1:0]          mag_x_next, mag_y_next, mag_z_next;
    logic [RADIUS_BITS-1:0] rad_a_reg;
    logic                   last_a_reg;

    // Stage B: squares.
    logic                   b_valid_reg, b_valid_next;
    logic [SQW-1:0]         sq_x_reg, sq_y_reg, sq_z_reg;
    logic [SQW-1:0]         sq_x_next, sq_y_next, sq_z_next;
    logic [RADIUS_BITS-1:0] rad_b_reg;
    logic                   last_b_reg;

    // Stage C: distance compare.
    logic                   c_valid_reg, c_valid_next;
    logic                   hit_c_reg, hit_c_next;
    logic                   last_c_reg;

    logic [CB:0]            dx, dy, dz, nx, ny, nz;
    logic [SUMW-1:0]        dist_sq;

    always_comb
    begin
        // Sign-extend by one bit so the difference is exact.
        dx = {query_x[CB-1], query_x} - {point_x[CB-1], point_x};
        dy = {query_y[CB-1], query_y} - {point_y[CB-1], point_y};
        dz = {query_z[CB-1], query_z} - {point_z[CB-1], point_z};
        nx = -dx;
        ny = -dy;
        nz = -dz;
        // Magnitude stays below 2^CB, so CB bits hold it.
        mag_x_next = dx[CB] ? nx[CB-1:0] : dx[CB-1:0];
        mag_y_next = dy[CB] ? ny[CB-1:0] : dy[CB-1:0];
        mag_z_next = dz[CB] ? nz[CB-1:0] : dz[CB-1:0];
        a_valid_next = in_valid;

        sq_x_next = SQW'(mag_x_reg) * SQW'(mag_x_reg);
        sq_y_next = SQW'(mag_y_reg) * SQW'(mag_y_reg);
        sq_z_next = SQW'(mag_z_reg) * SQW'(mag_z_reg);
        b_valid_next = a_valid_reg;

        dist_sq = SUMW'(sq_x_reg) + SUMW'(sq_y_reg) + SUMW'(sq_z_reg);
        hit_c_next   = CMPW'(rad_b_reg) > CMPW'(dist_sq);
        c_valid_next = b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        mag_x_reg  <= mag_x_next;
        mag_y_reg  <= mag_y_next;
        mag_z_reg  <= mag_z_next;
        rad_a_reg  <= radius_sq;
        last_a_reg <= last_point;
        sq_x_reg   <= sq_x_next;
        sq_y_reg   <= sq_y_next;
        sq_z_reg   <= sq_z_next;
        rad_b_reg  <= rad_a_reg;
        last_b_reg <= last_a_reg;
        hit_c_reg  <= hit_c_next;
        last_c_reg <= last_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    assign out_valid     = c_valid_reg;
    assign out_item.hit  = hit_c_reg;
    assign out_item.last = last_c_reg;
    assign stat.a_valid  = a_valid_reg;
    assign stat.b_valid  = b_valid_reg;
    assign stat.c_valid  = c_valid_reg;

endmodule

// File: hdl/fprs_back.sv
// Search sequencer: track point index and match state, emit results.
module fprs_back
    import fprs_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mid_valid,
    input  mid_item_t mid_item,
    output logic      mid_pop,
    input  logic      res_full,
    output logic      res_push,
    output result_t   res
);

    localparam logic [INDEX_BITS-1:0] IDX_CAP = index_cap(MAX_POINTS);

    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic                  done_reg, done_next;
    logic                  take;

    assign take    = mid_valid && !res_full;
    assign mid_pop = take;

    always_comb
    begin
        // Report a first match, or a miss on the last point of a search.
        res_push  = take && !done_reg && (mid_item.hit || mid_item.last);
        res.found = mid_item.hit;
        res.index = mid_item.hit ? idx_reg : '0;
    end

    always_comb
    begin
        idx_next  = idx_reg;
        done_next = done_reg;
        if (take)
        begin
            if (mid_item.last)
            begin
                idx_next  = '0;
                done_next = 1'b0;
            end
            else
            begin
                done_next = done_reg || mid_item.hit;
                if (idx_reg < IDX_CAP)
                begin
                    idx_next = idx_reg + INDEX_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            done_reg <= done_next;
        end
    end

endmodule

// File: hdl/first_point_within_radius_search.sv
// Top level of the first-point-within-radius search block.
//
// Usage: load the query position through the config channel (cfg_index 0..2
// for x, y, z; cfg_ready is always high), then push candidate points, one
// request per cycle while full is low. Mark the final point of each search
// with last_point. For each search the result queue gets exactly one request:
// found=1 with the index of the first point whose radius_sq exceeds its
// squared distance, or found=0 and index 0 after the last point. Points after
// a match are dropped without a result.
// Path: three distance stages, the middle queue, the sequencer step, then
// the output queue. Throughput: one point per cycle while full is low, set
// by the pipelined distance unit and the single-step sequencer.
// Stall: when pop stays low, results collect in a 2-entry output queue, then
// classified points back up in an 8-entry middle queue; full rises once the
// middle queue plus points in flight could overflow it.
// Reset: clears the query to the origin, the point index, the match flag and
// both queues.
module first_point_within_radius_search
    import fprs_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Point requests
    input  logic                      push,
    output logic                      full,
    input  logic [COORD_BITS-1:0]     point_x,
    input  logic [COORD_BITS-1:0]     point_y,
    input  logic [COORD_BITS-1:0]     point_z,
    input  logic [RADIUS_BITS-1:0]    radius_sq,
    input  logic                      last_point,
    // Result requests
    output logic                      empty,
    input  logic                      pop,
    output logic                      found,
    output logic [INDEX_BITS-1:0]     match_index,
    // Configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]     cfg_data
);

    localparam int MCW  = $clog2(MID_DEPTH + 1);
    localparam int OCW  = $clog2(OUT_DEPTH + 1);
    localparam int FILW = MCW + 1;

    logic [COORD_BITS-1:0] query_x_reg, query_y_reg, query_z_reg;
    logic [COORD_BITS-1:0] query_x_next, query_y_next, query_z_next;

    logic              accept;
    logic              front_valid;
    mid_item_t         front_item;
    front_stat_t       front_stat;

    logic              mid_empty, mid_full, mid_pop;
    logic [MCW-1:0]    mid_count;
    mid_item_t         mid_item;
    logic [FILW-1:0]   mid_fill;

    logic              res_push, res_full;
    logic [OCW-1:0]    res_count;
    result_t           res_in, res_out;

    // Config registers: writes take effect in the next cycle, unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        query_x_next = query_x_reg;
        query_y_next = query_y_reg;
        query_z_next = query_z_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_QUERY_X: query_x_next = cfg_data;
                REG_QUERY_Y: query_y_next = cfg_data;
                REG_QUERY_Z: query_z_next = cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x_reg <= '0;
            query_y_reg <= '0;
            query_z_reg <= '0;
        end
        else
        begin
            query_x_reg <= query_x_next;
            query_y_reg <= query_y_next;
            query_z_reg <= query_z_next;
        end
    end

    // Hold off new points while the middle queue plus the distance
    // pipeline could fill it; the pipeline itself never stalls.
    assign mid_fill = FILW'(mid_count) + FILW'(front_stat.a_valid)
                    + FILW'(front_stat.b_valid) + FILW'(front_stat.c_valid);
    assign full     = (mid_fill >= FILW'(MID_DEPTH));
    assign accept   = push && !full;

    fprs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .radius_sq  (radius_sq),
        .last_point (last_point),
        .query_x    (query_x_reg),
        .query_y    (query_y_reg),
        .query_z    (query_z_reg),
        .out_valid  (front_valid),
        .out_item   (front_item),
        .stat       (front_stat)
    );

    fprs_queue #(
        .WIDTH ($bits(mid_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_item),
        .rd_en   (mid_pop),
        .rd_data (mid_item),
        .empty   (mid_empty),
        .full    (mid_full),
        .count   (mid_count)
    );

    fprs_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (!mid_empty),
        .mid_item  (mid_item),
        .mid_pop   (mid_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // Result queue: parts the sequencer from a stalled receiver.
    fprs_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty),
        .full    (res_full),
        .count   (res_count)
    );

    assign found       = res_out.found;
    assign match_index = res_out.index;

endmodule

// File: hdl/fprs_checker.sv
// Port-level checker of the radius search block, bound to the top level.
`include "first_point_within_radius_search_assert.svh"

module fprs_checker
    import fprs_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input logic                  found,
    input logic [INDEX_BITS-1:0] match_index,
    input logic                  cfg_ready
);

    localparam logic [INDEX_BITS-1:0] IDX_CAP = index_cap(MAX_POINTS);

    `FPRS_ASSERT_ALL(a_reset_idle, !rst_n |-> (empty && !full), "queues not idle in reset")
    `FPRS_ASSERT(a_result_hold, (!empty && !pop) |=> (!empty && $stable(found) && $stable(match_index)), "stalled result changed")
    `FPRS_ASSERT(a_miss_index, (!empty && !found) |-> (match_index == '0), "miss carries nonzero index")
    `FPRS_ASSERT(a_index_cap, (!empty && cfg_ready) |-> (match_index <= IDX_CAP), "index beyond cap")

endmodule

bind first_point_within_radius_search fprs_checker #(
    .MAX_POINTS (MAX_POINTS)
) u_fprs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .found       (found),
    .match_index (match_index),
    .cfg_ready   (cfg_ready)
);
